[design/pmdv_pkg.sv]
// Package with the beat types, constants and direction table of the direction vector block.
package pmdv_pkg;

  localparam int unsigned NumDirs = 14;
  localparam int unsigned DirIdxW = 4;
  localparam int unsigned CompW = 32;
  localparam int unsigned NormW = 35;
  localparam int unsigned SumW = 66;
  localparam int unsigned QuoW = 128;
  localparam int unsigned DivStages = 32;

  typedef struct packed {
    logic signed [31:0] first_col_x;
    logic signed [31:0] first_col_y;
    logic signed [31:0] first_col_z;
    logic signed [31:0] second_col_x;
    logic signed [31:0] second_col_y;
    logic signed [31:0] second_col_z;
    logic signed [31:0] jac_det;
  } pmdv_in_t;

  typedef struct packed {
    logic [3:0]         dir_index;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic               last_vector;
    logic               range_fault;
  } pmdv_out_t;

  typedef enum logic [1:0] {
    SelN1 = 2'd0,
    SelND = 2'd1,
    SelN2 = 2'd2
  } norm_sel_e;

  typedef enum logic [1:0] {
    CoefZero = 2'd0,
    CoefPos  = 2'd1,
    CoefNeg  = 2'd2
  } coef_e;

  typedef struct packed {
    coef_e     c1;
    coef_e     c2;
    norm_sel_e nm;
    norm_sel_e nx;
    logic      mid;
  } dir_entry_t;

  function automatic dir_entry_t dir_entry(input logic [3:0] k);
    dir_entry_t e;
    e = '{CoefZero, CoefZero, SelN1, SelN1, 1'b0};
    unique case (k)
      4'd0:  e = '{CoefZero, CoefNeg, SelN1, SelN1, 1'b0};
      4'd1:  e = '{CoefPos, CoefNeg, SelN1, SelN1, 1'b0};
      4'd2:  e = '{CoefZero, CoefZero, SelN1, SelN1, 1'b1};
      4'd3:  e = '{CoefPos, CoefZero, SelND, SelND, 1'b0};
      4'd4:  e = '{CoefZero, CoefPos, SelND, SelND, 1'b0};
      4'd5:  e = '{CoefZero, CoefZero, SelN1, SelN1, 1'b1};
      4'd6:  e = '{CoefNeg, CoefPos, SelN2, SelN2, 1'b0};
      4'd7:  e = '{CoefNeg, CoefZero, SelN2, SelN2, 1'b0};
      4'd8:  e = '{CoefZero, CoefZero, SelN1, SelN1, 1'b1};
      4'd9:  e = '{CoefPos, CoefZero, SelN1, SelN1, 1'b0};
      4'd10: e = '{CoefNeg, CoefPos, SelND, SelND, 1'b0};
      4'd11: e = '{CoefZero, CoefNeg, SelN2, SelN2, 1'b0};
      4'd12: e = '{CoefPos, CoefZero, SelN2, SelN1, 1'b0};
      4'd13: e = '{CoefZero, CoefPos, SelN1, SelND, 1'b0};
      default: e = '{CoefZero, CoefZero, SelN1, SelN1, 1'b0};
    endcase
    return e;
  endfunction

endpackage

[design/pmdv_sqrt.sv]
// Pipelined integer square root, five result bits per stage.
module pmdv_sqrt
  import pmdv_pkg::*;
#(
  parameter int unsigned TagW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SumW-1:0]   rad_i,
  input  logic [TagW-1:0]   tag_i,
  output logic              valid_o,
  output logic [NormW-1:0]  root_o,
  output logic [TagW-1:0]   tag_o
);

  localparam int unsigned BitsPerStage = 5;
  localparam int unsigned Stages = NormW / BitsPerStage;
  localparam int unsigned RadW = 2 * NormW;
  localparam int unsigned RemW = NormW + 3;

  logic [Stages:0]                valid_q;
  logic [RadW-1:0]                rad_q  [Stages+1];
  logic [RemW-1:0]                rem_q  [Stages+1];
  logic [NormW-1:0]               root_q [Stages+1];
  logic [TagW-1:0]                tag_q  [Stages+1];

  always_comb begin
    valid_q[0] = valid_i;
    rad_q[0]   = RadW'(rad_i);
    rem_q[0]   = '0;
    root_q[0]  = '0;
    tag_q[0]   = tag_i;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [RadW-1:0]  rad_d;
    logic [RemW-1:0]  rem_d;
    logic [NormW-1:0] root_d;
    always_comb begin
      logic [RemW-1:0] trial;
      rad_d  = rad_q[s];
      rem_d  = rem_q[s];
      root_d = root_q[s];
      for (int b = 0; b < BitsPerStage; b++) begin
        rem_d = {rem_d[RemW-3:0], rad_d[RadW-1 -: 2]};
        rad_d = {rad_d[RadW-3:0], 2'b00};
        trial = {1'b0, root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[NormW-2:0], 1'b1};
        end else begin
          root_d = {root_d[NormW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= valid_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s+1]  <= rad_d;
        rem_q[s+1]  <= rem_d;
        root_q[s+1] <= root_d;
        tag_q[s+1]  <= tag_q[s];
      end
    end
  end

  assign valid_o = valid_q[Stages];
  assign root_o  = root_q[Stages];
  assign tag_o   = tag_q[Stages];

endmodule

[design/pmdv_div.sv]
// Pipelined rounded signed division with saturation for one vector component.
module pmdv_div
  import pmdv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [QuoW-1:0]        num_i,
  input  logic [QuoW-1:0]        den_i,
  input  logic                   neg_i,
  output logic signed [CompW-1:0] quo_o,
  output logic                   fault_o
);

  localparam int unsigned BitsPerStage = QuoW / DivStages;

  logic [QuoW-1:0] n_q   [DivStages+1];
  logic [QuoW-1:0] d_q   [DivStages+1];
  logic [QuoW-1:0] r_q   [DivStages+1];
  logic [QuoW-1:0] q_q   [DivStages+1];
  logic            neg_q [DivStages+1];
  logic            nz_q  [DivStages+1];

  always_comb begin
    n_q[0]   = {num_i[QuoW-2:0], 1'b0} + den_i;
    d_q[0]   = {den_i[QuoW-2:0], 1'b0};
    r_q[0]   = '0;
    q_q[0]   = '0;
    neg_q[0] = neg_i;
    nz_q[0]  = (num_i != '0);
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [QuoW-1:0] r_d, q_d, n_d;
    always_comb begin
      r_d = r_q[s];
      q_d = q_q[s];
      n_d = n_q[s];
      for (int b = 0; b < BitsPerStage; b++) begin
        r_d = {r_d[QuoW-2:0], n_d[QuoW-1]};
        n_d = {n_d[QuoW-2:0], 1'b0};
        q_d = {q_d[QuoW-2:0], 1'b0};
        if (r_d >= d_q[s]) begin
          r_d    = r_d - d_q[s];
          q_d[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s+1]   <= n_d;
        d_q[s+1]   <= d_q[s];
        r_q[s+1]   <= r_d;
        q_q[s+1]   <= q_d;
        neg_q[s+1] <= neg_q[s];
        nz_q[s+1]  <= nz_q[s];
      end
    end
  end

  logic [QuoW-1:0] q_last;
  logic            zero_den;
  assign q_last   = q_q[DivStages];
  assign zero_den = (d_q[DivStages] == '0);

  always_comb begin
    fault_o = 1'b0;
    quo_o   = '0;
    if (zero_den) begin
      fault_o = 1'b1;
      if (nz_q[DivStages]) begin
        quo_o = neg_q[DivStages] ? {1'b1, {(CompW-1){1'b0}}} : {1'b0, {(CompW-1){1'b1}}};
      end
    end else if (neg_q[DivStages]) begin
      if (q_last > QuoW'(64'h8000_0000)) begin
        fault_o = 1'b1;
        quo_o   = {1'b1, {(CompW-1){1'b0}}};
      end else begin
        quo_o = CompW'(-q_last);
      end
    end else begin
      if (q_last > QuoW'(64'h7FFF_FFFF)) begin
        fault_o = 1'b1;
        quo_o   = {1'b0, {(CompW-1){1'b1}}};
      end else begin
        quo_o = CompW'(q_last);
      end
    end
  end

endmodule

[design/piola_mapped_direction_vectors.sv]
// Top level of the direction vector block: Jacobian in, fourteen scaled directions out.
//
// The input channel takes one beat per Jacobian (two columns and the determinant,
// signed Q16.16). The output channel sends fourteen beats per Jacobian, index 0 to 13,
// with last_vector on index 13 and range_fault on any saturated or zero-divisor beat.
// Three norms are found by three pipelined square roots; then a sequencer issues one
// direction per cycle while the output is not stalled, into a three-lane pipelined
// divider. Midpoint directions are formed from the two preceding saturated directions
// at the output. Throughput is limited by the single output port; a new Jacobian may
// enter while earlier ones are still in flight. The first beat follows the accept through
// stage A, the square roots, the sequencer, stage P, the divider and the output register.
// After an accept, ready stays low until a gap counter, counted down only while not stalled, is zero.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and sets scale_q to zero.
module piola_mapped_direction_vectors
  import pmdv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pmdv_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pmdv_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  localparam int unsigned TagW = 7 * CompW;
  localparam int unsigned Lat = DivStages;

  logic scale_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 1'b0;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || out_ready_i;

  // Stage A: squared sums of the two columns and of their difference.
  logic            a_vld_q;
  pmdv_in_t        a_in_q;
  logic [SumW-1:0] s1_q, sd_q, s2_q;
  logic [3:0]      gap_q;
  assign in_ready_o = en && (gap_q == '0);

  function automatic logic [SumW-1:0] sq3(input logic signed [32:0] x,
                                          input logic signed [32:0] y,
                                          input logic signed [32:0] z);
    logic [32:0] mx, my, mz;
    mx = x[32] ? 33'(-x) : 33'(x);
    my = y[32] ? 33'(-y) : 33'(y);
    mz = z[32] ? 33'(-z) : 33'(z);
    return SumW'(66'(mx) * 66'(mx)) + SumW'(66'(my) * 66'(my)) + SumW'(66'(mz) * 66'(mz));
  endfunction

  logic acc;
  assign acc = in_valid_i && in_ready_o;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= acc;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (acc) begin
      gap_q <= 4'(NumDirs - 1);
    end else if (en && gap_q != '0) begin
      gap_q <= gap_q - 4'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en && acc) begin
      a_in_q <= in_data_i;
      s1_q <= sq3(33'(in_data_i.first_col_x), 33'(in_data_i.first_col_y),
                  33'(in_data_i.first_col_z));
      s2_q <= sq3(33'(in_data_i.second_col_x), 33'(in_data_i.second_col_y),
                  33'(in_data_i.second_col_z));
      sd_q <= sq3(33'(in_data_i.first_col_x) - 33'(in_data_i.second_col_x),
                  33'(in_data_i.first_col_y) - 33'(in_data_i.second_col_y),
                  33'(in_data_i.first_col_z) - 33'(in_data_i.second_col_z));
    end
  end

  logic sq_vld, unused_v1, unused_v2;
  logic [NormW-1:0] n1, nd, n2;
  logic [TagW-1:0] tag_out, unused_t1, unused_t2;
  pmdv_sqrt #(.TagW(TagW)) u_sqrt1 (.clk_i, .rst_ni, .en_i(en), .valid_i(a_vld_q), .rad_i(s1_q),
    .tag_i(a_in_q), .valid_o(sq_vld), .root_o(n1), .tag_o(tag_out));
  pmdv_sqrt #(.TagW(TagW)) u_sqrtd (.clk_i, .rst_ni, .en_i(en), .valid_i(a_vld_q), .rad_i(sd_q),
    .tag_i(a_in_q), .valid_o(unused_v1), .root_o(nd), .tag_o(unused_t1));
  pmdv_sqrt #(.TagW(TagW)) u_sqrt2 (.clk_i, .rst_ni, .en_i(en), .valid_i(a_vld_q), .rad_i(s2_q),
    .tag_i(a_in_q), .valid_o(unused_v2), .root_o(n2), .tag_o(unused_t2));

  // Sequencer holding one Jacobian and its norms while the directions issue.
  logic             seq_vld_q;
  logic [3:0]       k_q;
  pmdv_in_t         j_q;
  logic [NormW-1:0] n1_q, nd_q, n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_vld_q <= 1'b0;
      k_q <= '0;
    end else if (en) begin
      if (sq_vld) begin
        seq_vld_q <= 1'b1;
        k_q <= '0;
      end else if (seq_vld_q) begin
        if (k_q == 4'(NumDirs - 1)) begin
          seq_vld_q <= 1'b0;
        end
        k_q <= k_q + 4'd1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en && sq_vld) begin
      j_q  <= pmdv_in_t'(tag_out);
      n1_q <= n1;
      nd_q <= nd;
      n2_q <= n2;
    end
  end

  function automatic logic [NormW-1:0] pick(input norm_sel_e s, input logic [NormW-1:0] a,
                                            input logic [NormW-1:0] d, input logic [NormW-1:0] b);
    logic [NormW-1:0] r;
    r = a;
    unique case (s)
      SelN1: r = a;
      SelND: r = d;
      SelN2: r = b;
      default: r = a;
    endcase
    return r;
  endfunction

  function automatic logic signed [33:0] term(input coef_e c, input logic signed [31:0] v);
    logic signed [33:0] r;
    r = '0;
    unique case (c)
      CoefZero: r = '0;
      CoefPos:  r = 34'(v);
      CoefNeg:  r = -34'(v);
      default:  r = '0;
    endcase
    return r;
  endfunction

  // Stage P: numerator products per lane and the denominator shared by all lanes.
  dir_entry_t       ent;
  logic [NormW-1:0] nm, nx;
  logic [31:0]      dmag;
  assign ent  = dir_entry(k_q);
  assign nm   = pick(ent.nm, n1_q, nd_q, n2_q);
  assign nx   = pick(ent.nx, n1_q, nd_q, n2_q);
  assign dmag = j_q.jac_det[31] ? 32'(-j_q.jac_det) : 32'(j_q.jac_det);

  logic signed [33:0] av [3];
  always_comb begin
    av[0] = term(ent.c1, j_q.first_col_x) + term(ent.c2, j_q.second_col_x);
    av[1] = term(ent.c1, j_q.first_col_y) + term(ent.c2, j_q.second_col_y);
    av[2] = term(ent.c1, j_q.first_col_z) + term(ent.c2, j_q.second_col_z);
  end

  logic            p_vld_q;
  logic [3:0]      p_k_q;
  logic            p_mid_q;
  logic [QuoW-1:0] p_num_q [3];
  logic [QuoW-1:0] p_den_q;
  logic            p_neg_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= seq_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_k_q   <= k_q;
      p_mid_q <= ent.mid;
      p_den_q <= scale_q ? QuoW'(67'(nx) * 67'(dmag)) : QuoW'(dmag);
      for (int i = 0; i < 3; i++) begin
        logic [32:0] am;
        am = av[i][33] ? 33'(-av[i]) : 33'(av[i]);
        p_num_q[i] <= scale_q ? (QuoW'(68'(am) * 68'(nm)) << 17) : QuoW'(68'(am) * 68'(nm));
        p_neg_q[i] <= av[i][33] != j_q.jac_det[31];
      end
    end
  end

  logic signed [CompW-1:0] q_c [3];
  logic                    q_f [3];
  for (genvar i = 0; i < 3; i++) begin : g_lane
    pmdv_div u_div (.clk_i, .rst_ni, .en_i(en), .num_i(p_num_q[i]), .den_i(p_den_q),
      .neg_i(p_neg_q[i]), .quo_o(q_c[i]), .fault_o(q_f[i]));
  end

  logic [Lat-1:0] d_vld_q;
  logic [3:0]     d_k_q   [Lat];
  logic           d_mid_q [Lat];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= '0;
    end else if (en) begin
      d_vld_q <= {d_vld_q[Lat-2:0], p_vld_q};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_k_q[0]   <= p_k_q;
      d_mid_q[0] <= p_mid_q;
      for (int s = 1; s < Lat; s++) begin
        d_k_q[s]   <= d_k_q[s-1];
        d_mid_q[s] <= d_mid_q[s-1];
      end
    end
  end

  // The divider output lines up with the last delay stage.
  logic                    r_vld;
  logic [3:0]              r_k;
  logic                    r_mid;
  assign r_vld = d_vld_q[Lat-1];
  assign r_k   = d_k_q[Lat-1];
  assign r_mid = d_mid_q[Lat-1];

  logic signed [CompW-1:0] h1_q [3];
  logic signed [CompW-1:0] h2_q [3];
  logic                    hf1_q, hf2_q;
  pmdv_out_t               out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= r_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en && r_vld) begin
      logic signed [CompW:0] sm [3];
      out_q.dir_index   <= r_k;
      out_q.last_vector <= (r_k == 4'(NumDirs - 1));
      if (r_mid) begin
        for (int i = 0; i < 3; i++) begin
          sm[i] = 33'(h1_q[i]) + 33'(h2_q[i]);
        end
        out_q.comp_x      <= CompW'(sm[0] >>> 1);
        out_q.comp_y      <= CompW'(sm[1] >>> 1);
        out_q.comp_z      <= CompW'(sm[2] >>> 1);
        out_q.range_fault <= hf1_q || hf2_q;
      end else begin
        out_q.comp_x      <= q_c[0];
        out_q.comp_y      <= q_c[1];
        out_q.comp_z      <= q_c[2];
        out_q.range_fault <= q_f[0] || q_f[1] || q_f[2];
        for (int i = 0; i < 3; i++) begin
          h2_q[i] <= h1_q[i];
          h1_q[i] <= q_c[i];
        end
        hf2_q <= hf1_q;
        hf1_q <= q_f[0] || q_f[1] || q_f[2];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_vector |-> out_data_o.dir_index == 4'(NumDirs - 1))
    else $error("last_vector on a beat other than the final direction");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld |-> !seq_vld_q || k_q == 4'(NumDirs - 1))
    else $error("norms arrived while directions still issue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unused_v1 == sq_vld && unused_v2 == sq_vld &&
    (!sq_vld || (unused_t1 == tag_out && unused_t2 == tag_out)))
    else $error("square root lanes out of step");

endmodule

[verif/pmdv_checker.sv]
// Checker that predicts the fourteen direction vectors per Jacobian and compares output beats.
`timescale 1ns / 1ps
module pmdv_checker
  import pmdv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  pmdv_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  pmdv_out_t out_data_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        jacobians_o,
  output int        vectors_o
);

  localparam logic signed [31:0] QMax = 32'sh7fffffff;
  localparam logic signed [31:0] QMin = 32'sh80000000;

  pmdv_out_t dirs_due[$];
  bit        scale_on;

  function automatic logic [127:0] floor_sqrt(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = NormW - 1; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [127:0] mag64(input logic signed [63:0] v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    return {64'd0, m};
  endfunction

  function automatic logic signed [31:0] ratio_sat(input logic signed [63:0] a,
                                                   input logic [127:0] nm,
                                                   input logic [127:0] nx,
                                                   input logic signed [63:0] det,
                                                   inout bit fault);
    bit neg;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    neg = (a < 0) != (det < 0);
    num = mag64(a) * nm;
    if (scale_on) begin
      num = num << 17;
      den = nx * mag64(det);
    end else begin
      den = mag64(det);
    end
    if (den == 0) begin
      fault = 1'b1;
      if (num == 0) return '0;
      return neg ? QMin : QMax;
    end
    q = ((num << 1) + den) / (den << 1);
    if (neg) begin
      if (q > 128'h80000000) begin
        fault = 1'b1;
        return QMin;
      end
      return -q[31:0];
    end
    if (q > 128'h7fffffff) begin
      fault = 1'b1;
      return QMax;
    end
    return q[31:0];
  endfunction

  function automatic logic signed [63:0] coef_apply(input coef_e c, input logic signed [63:0] v);
    case (c)
      CoefPos: return v;
      CoefNeg: return -v;
      default: return '0;
    endcase
  endfunction

  task automatic predict_directions(input pmdv_in_t j);
    logic signed [63:0] v1 [3];
    logic signed [63:0] v2 [3];
    logic signed [63:0] dv [3];
    logic signed [63:0] det;
    logic signed [63:0] a;
    logic signed [63:0] sum;
    logic [127:0] norms [3];
    logic signed [31:0] comp [NumDirs][3];
    bit flt [NumDirs];
    coef_e c1, c2;
    norm_sel_e nm, nx;
    int p;
    pmdv_out_t o;
    v1[0] = j.first_col_x;
    v1[1] = j.first_col_y;
    v1[2] = j.first_col_z;
    v2[0] = j.second_col_x;
    v2[1] = j.second_col_y;
    v2[2] = j.second_col_z;
    det = j.jac_det;
    for (int i = 0; i < 3; i++) dv[i] = v1[i] - v2[i];
    norms[SelN1] = floor_sqrt(mag64(v1[0]) * mag64(v1[0]) + mag64(v1[1]) * mag64(v1[1])
                              + mag64(v1[2]) * mag64(v1[2]));
    norms[SelND] = floor_sqrt(mag64(dv[0]) * mag64(dv[0]) + mag64(dv[1]) * mag64(dv[1])
                              + mag64(dv[2]) * mag64(dv[2]));
    norms[SelN2] = floor_sqrt(mag64(v2[0]) * mag64(v2[0]) + mag64(v2[1]) * mag64(v2[1])
                              + mag64(v2[2]) * mag64(v2[2]));
    for (int k = 0; k < NumDirs; k++) begin
      flt[k] = 1'b0;
      c1 = CoefZero;
      c2 = CoefZero;
      nm = SelN1;
      nx = SelN1;
      p = -1;
      case (k)
        0:  begin c2 = CoefNeg; end
        1:  begin c1 = CoefPos; c2 = CoefNeg; end
        2:  p = 0;
        3:  begin c1 = CoefPos; nm = SelND; nx = SelND; end
        4:  begin c2 = CoefPos; nm = SelND; nx = SelND; end
        5:  p = 3;
        6:  begin c1 = CoefNeg; c2 = CoefPos; nm = SelN2; nx = SelN2; end
        7:  begin c1 = CoefNeg; nm = SelN2; nx = SelN2; end
        8:  p = 6;
        9:  begin c1 = CoefPos; end
        10: begin c1 = CoefNeg; c2 = CoefPos; nm = SelND; nx = SelND; end
        11: begin c2 = CoefNeg; nm = SelN2; nx = SelN2; end
        12: begin c1 = CoefPos; nm = SelN2; nx = SelN1; end
        default: begin c2 = CoefPos; nm = SelN1; nx = SelND; end
      endcase
      for (int i = 0; i < 3; i++) begin
        if (p >= 0) begin
          sum = 64'(comp[p][i]) + 64'(comp[p + 1][i]);
          comp[k][i] = 32'(sum >>> 1);
        end else begin
          a = coef_apply(c1, v1[i]) + coef_apply(c2, v2[i]);
          comp[k][i] = ratio_sat(a, norms[nm], norms[nx], det, flt[k]);
        end
      end
      if (p >= 0) flt[k] = flt[p] || flt[p + 1];
      o.dir_index   = 4'(k);
      o.comp_x      = comp[k][0];
      o.comp_y      = comp[k][1];
      o.comp_z      = comp[k][2];
      o.last_vector = (k == NumDirs - 1);
      o.range_fault = flt[k];
      dirs_due.push_back(o);
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    jacobians_o = 0;
    vectors_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    pmdv_out_t want;
    if (!rst_ni) begin
      scale_on = 1'b0;
    end else begin
      if (cfg_we_i) scale_on = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        predict_directions(in_data_i);
        jacobians_o++;
      end
      if (out_valid_i && out_ready_i) begin
        vectors_o++;
        if (dirs_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("ERROR: unexpected beat index %0d at %0t", out_data_i.dir_index, $realtime);
        end else begin
          want = dirs_due.pop_front();
          if (out_data_i.dir_index !== want.dir_index || out_data_i.comp_x !== want.comp_x ||
              out_data_i.comp_y !== want.comp_y || out_data_i.comp_z !== want.comp_z ||
              out_data_i.last_vector !== want.last_vector ||
              out_data_i.range_fault !== want.range_fault) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("ERROR: beat mismatch, expected idx=%0d x=%h y=%h z=%h last=%b flt=%b, got idx=%0d x=%h y=%h z=%h last=%b flt=%b",
                       want.dir_index, want.comp_x, want.comp_y, want.comp_z,
                       want.last_vector, want.range_fault,
                       out_data_i.dir_index, out_data_i.comp_x, out_data_i.comp_y,
                       out_data_i.comp_z, out_data_i.last_vector, out_data_i.range_fault);
          end
        end
      end
      pending_o = dirs_due.size();
    end
  end

endmodule

[verif/tb_piola_mapped_direction_vectors.sv]
// Testbench top that drives Jacobians and configuration into the direction vector block.
`timescale 1ns / 1ps
module tb_piola_mapped_direction_vectors;
  import pmdv_pkg::*;

  localparam int RandItems = 440;
  localparam int SettleCycles = 40;
  localparam int IdleLimit = 20000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  pmdv_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  pmdv_out_t out_data_o;
  logic      cfg_we_i;
  logic      cfg_wdata_i;
  int        fail_count;
  int        pending;
  int        jacobians;
  int        vectors;
  bit        calm;
  int        idle_cycles = 0;

  piola_mapped_direction_vectors DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pmdv_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .jacobians_o  (jacobians),
    .vectors_o    (vectors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  always @(posedge clk_i) begin
    if (calm) out_ready_i <= 1'b1;
    else out_ready_i <= (gap_len() == 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired with %0d vectors still due", pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed(32'($urandom_range(0, 1 << 19))) - 32'sd262144;
      4, 5, 6:    return $urandom;
      7:          return 32'sh7fffffff;
      8:          return 32'sh80000000;
      default:    return '0;
    endcase
  endfunction

  function automatic pmdv_in_t random_jacobian();
    pmdv_in_t j;
    j.first_col_x  = pick_value();
    j.first_col_y  = pick_value();
    j.first_col_z  = pick_value();
    j.second_col_x = pick_value();
    j.second_col_y = pick_value();
    j.second_col_z = pick_value();
    if ($urandom_range(0, 9) == 0) begin
      j.second_col_x = j.first_col_x;
      j.second_col_y = j.first_col_y;
      j.second_col_z = j.first_col_z;
    end
    j.jac_det = ($urandom_range(0, 29) == 0) ? 32'sd0 : pick_value();
    return j;
  endfunction

  task automatic send_jacobian(input pmdv_in_t j);
    int g;
    in_valid_i <= 1'b1;
    in_data_i  <= j;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_set(input logic v);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_set();
    pmdv_in_t j;
    j = '{default: 32'sd0};
    send_jacobian(j);
    j = '{32'sh10000, 32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sh10000};
    send_jacobian(j);
    j = '{default: 32'sh7fffffff};
    send_jacobian(j);
    j = '{default: 32'sh80000000};
    send_jacobian(j);
    j = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
          32'sh80000000, 32'sd1};
    send_jacobian(j);
    j = '{32'sh18000, -32'sh8000, 32'sh4000, 32'sh18000, -32'sh8000, 32'sh4000, -32'sd1};
    send_jacobian(j);
    j = '{32'sd0, 32'sd0, 32'sd0, 32'sh20000, -32'sh30000, 32'sh1000, 32'sh8000};
    send_jacobian(j);
    j = '{-32'sh20000, 32'sh10000, 32'sd7, 32'sh10000, 32'sh20000, -32'sd3, 32'sd0};
    send_jacobian(j);
    j = '{32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sh80000000};
    send_jacobian(j);
    j = '{32'sh5555aaaa, 32'shaaaa5555, 32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh12345678,
          32'shedcba987, 32'sh7fffffff};
    send_jacobian(j);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    calm        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_set();
    drain_and_set(1'b1);
    directed_set();
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_set(ph[0]);
      calm = (ph == 2);
      for (int n = 0; n < RandItems / 4; n++) send_jacobian(random_jacobian());
      calm = 1'b0;
    end
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d Jacobians and %0d direction vectors with scaling off and on,",
             jacobians, vectors);
    $display("including saturation, zero determinants, zero norms and output stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[piola_mapped_direction_vectors.f]
design/pmdv_pkg.sv
design/pmdv_sqrt.sv
design/pmdv_div.sv
design/piola_mapped_direction_vectors.sv
verif/pmdv_checker.sv
verif/tb_piola_mapped_direction_vectors.sv
